[rtl/cep_pkg.sv]
// Shared constants, types and arithmetic helpers for the camera pose unit.
// No dependencies; cep_cordic and the top file refer to it by scoped names.
package cep_pkg;

    localparam int TRIG_ITERATIONS = 16;
    localparam int POS_FRAC_BITS   = 16;
    localparam int ANG_TABLE_LEN   = 24;
    localparam int CORDIC_STEPS    = (TRIG_ITERATIONS < ANG_TABLE_LEN) ?
                                     TRIG_ITERATIONS : ANG_TABLE_LEN;
    localparam int STEP_W          = $clog2(CORDIC_STEPS);
    localparam int MOVE_SHIFT      = 38 - POS_FRAC_BITS;

    localparam logic [63:0] POS_Y_WIDE  = 64'd150 << POS_FRAC_BITS;
    localparam logic [31:0] POS_Y_RESET = (POS_Y_WIDE > 64'd2147483647) ?
                                          32'h7FFF_FFFF : POS_Y_WIDE[31:0];

    localparam logic signed [31:0] CORDIC_K     = 32'sd652032874;
    localparam logic signed [31:0] ANG_QUARTER  = 32'sd94371840;
    localparam logic signed [31:0] ANG_HALF     = 32'sd188743680;
    localparam logic signed [15:0] VEC_ONE      = 16'sd16384;
    localparam logic signed [19:0] PITCH_LIMIT  = 20'sd11392;
    localparam logic signed [19:0] YAW_HALF     = 20'sd23040;
    localparam logic signed [19:0] YAW_TURN     = 20'sd46080;
    localparam logic signed [15:0] YAW_RESET    = -16'sd11520;

    localparam logic       REQ_MOVE   = 1'b0;
    localparam logic       REQ_ROTATE = 1'b1;

    localparam logic [2:0] DIR_FWD   = 3'd0;
    localparam logic [2:0] DIR_BACK  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;
    localparam logic [2:0] DIR_UP    = 3'd4;
    localparam logic [2:0] DIR_DOWN  = 3'd5;

    localparam logic REG_MOVE_SPEED = 1'b0;
    localparam logic REG_LOOK_SENS  = 1'b1;

    typedef struct packed {
        logic               start;
        logic signed [15:0] angle;   // Q.7 degrees
    } t_cordic_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_v;   // Q.30
        logic signed [31:0] sin_v;   // Q.30
    } t_cordic_rsp;

    // atan(2^-i) in degrees, Q.20
    function automatic logic signed [31:0] atan_q20(input logic [4:0] idx);
        logic signed [31:0] r;
        case (idx)
            5'd0:  r = 32'sd47185920;
            5'd1:  r = 32'sd27855475;
            5'd2:  r = 32'sd14718068;
            5'd3:  r = 32'sd7471121;
            5'd4:  r = 32'sd3750058;
            5'd5:  r = 32'sd1876857;
            5'd6:  r = 32'sd938658;
            5'd7:  r = 32'sd469357;
            5'd8:  r = 32'sd234682;
            5'd9:  r = 32'sd117342;
            5'd10: r = 32'sd58671;
            5'd11: r = 32'sd29335;
            5'd12: r = 32'sd14668;
            5'd13: r = 32'sd7334;
            5'd14: r = 32'sd3667;
            5'd15: r = 32'sd1833;
            5'd16: r = 32'sd917;
            5'd17: r = 32'sd458;
            5'd18: r = 32'sd229;
            5'd19: r = 32'sd115;
            5'd20: r = 32'sd57;
            5'd21: r = 32'sd29;
            5'd22: r = 32'sd14;
            5'd23: r = 32'sd7;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    // shift right, rounding half away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic [63:0] m;
        logic [63:0] r;
        m = v[63] ? 64'(-v) : 64'(v);
        r = (m + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [15:0] clamp_vec(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd16384) begin
            r = VEC_ONE;
        end else if (v < -64'sd16384) begin
            r = -VEC_ONE;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

[rtl/cep_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on nothing outside itself.
module cep_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [63:0] o_p
);

    logic signed [65:0] n_p;
    logic signed [63:0] r_p;

    assign n_p = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_p <= n_p[63:0];
    end

    assign o_p = r_p;

endmodule

[rtl/cep_cordic.sv]
// Iterative CORDIC: cosine and sine of a Q.7 degree angle, one rotation per cycle.
// Uses cep_pkg for the angle table, gain constant and request/response types.
module cep_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cep_pkg::t_cordic_req i_req,
    output cep_pkg::t_cordic_rsp o_rsp
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic                           r_flip, n_flip;
    logic [cep_pkg::STEP_W-1:0]     r_i, n_i;
    logic signed [31:0]             r_x, n_x;
    logic signed [31:0]             r_y, n_y;
    logic signed [31:0]             r_z, n_z;

    logic signed [31:0] z_in;
    logic signed [31:0] dx, dy, sx, sy, sz, at;
    logic               last;

    assign z_in = 32'(i_req.angle) <<< 13;
    assign dx   = r_y >>> r_i;
    assign dy   = r_x >>> r_i;
    assign at   = cep_pkg::atan_q20(5'(r_i));
    assign last = (r_i == cep_pkg::STEP_W'(cep_pkg::CORDIC_STEPS - 1));

    always_comb begin
        if (r_z >= 0) begin
            sx = r_x - dx;
            sy = r_y + dy;
            sz = r_z - at;
        end else begin
            sx = r_x + dx;
            sy = r_y - dy;
            sz = r_z + at;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_flip = r_flip;
        n_i    = r_i;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        if (r_busy) begin
            n_i = r_i + 1'b1;
            n_z = sz;
            if (last) begin
                // undo the half-turn fold on the way out
                n_x    = r_flip ? -sx : sx;
                n_y    = r_flip ? -sy : sy;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_x = sx;
                n_y = sy;
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_i    = '0;
            n_x    = cep_pkg::CORDIC_K;
            n_y    = 32'sd0;
            if (z_in > cep_pkg::ANG_QUARTER) begin
                n_z    = z_in - cep_pkg::ANG_HALF;
                n_flip = 1'b1;
            end else if (z_in < -cep_pkg::ANG_QUARTER) begin
                n_z    = z_in + cep_pkg::ANG_HALF;
                n_flip = 1'b1;
            end else begin
                n_z    = z_in;
                n_flip = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_flip <= n_flip;
        r_i    <= n_i;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.cos_v = r_x;
    assign o_rsp.sin_v = r_y;

endmodule

[rtl/euler_camera_pose_update_top.sv]
// Camera pose unit: sequencer around a shared multiplier and a CORDIC unit.
// Uses cep_pkg, cep_mul and cep_cordic.
// A move item forms the speed product, then multiplies and accumulates per axis; a rotate
// item scales both deltas, clamps pitch, wraps yaw (one turn per cycle), runs two CORDIC
// passes and the four products. One item at a time; ready again once its result is
// in the output register. Synchronous active-low reset restores the initial pose.
module euler_camera_pose_update_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // [2:0] move_direction, [18:3] time_step, [34:19] yaw_delta, [50:35] pitch_delta
    input  logic [55:0]   i_s_tdata,
    // [0] req_type
    input  logic          i_s_tuser,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [111:96] front_x, [127:112] front_y,
    // [143:128] front_z, [159:144] right_x, [175:160] right_z, [191:176] up_x,
    // [207:192] up_y, [223:208] up_z, [238:224] pitch_now
    output logic [239:0]  o_m_tdata,
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [2:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    output logic [31:0]   o_prdata,
    output logic          o_pready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_M_SPD = 4'd1;
    localparam logic [3:0] S_M_LD  = 4'd2;
    localparam logic [3:0] S_M_MUL = 4'd3;
    localparam logic [3:0] S_M_ACC = 4'd4;
    localparam logic [3:0] S_R_DY  = 4'd5;
    localparam logic [3:0] S_R_DP  = 4'd6;
    localparam logic [3:0] S_R_PCL = 4'd7;
    localparam logic [3:0] S_R_WRP = 4'd8;
    localparam logic [3:0] S_R_CY  = 4'd9;
    localparam logic [3:0] S_R_CP  = 4'd10;
    localparam logic [3:0] S_R_MUL = 4'd11;
    localparam logic [3:0] S_R_MST = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    logic [3:0]          r_state, n_state;
    logic [1:0]          r_k, n_k;
    logic [15:0]         r_speed, r_sens;
    logic [2:0]          r_dir;
    logic [15:0]         r_time;
    logic signed [15:0]  r_yd, r_pd;
    logic [31:0]         r_spd;
    logic signed [19:0]  r_acc;
    logic signed [31:0]  r_cy, r_sy, r_cp, r_sp;

    logic signed [31:0]  r_pos [3];
    logic signed [15:0]  r_yaw;
    logic signed [14:0]  r_pitch;
    logic signed [15:0]  r_fx, r_fy, r_fz, r_rx, r_rz, r_ux, r_uy, r_uz;

    logic                r_m_valid;
    logic [239:0]        r_m_data;

    logic                s_acc;
    logic                out_load;
    logic signed [32:0]  mul_a, mul_b;
    logic signed [63:0]  prod;
    logic signed [16:0]  vec_c;
    logic signed [63:0]  rnd_p;
    logic signed [63:0]  rnd_m;
    logic signed [33:0]  pos_sum;
    logic signed [31:0]  pos_sat;
    logic signed [19:0]  pitch_sum;
    logic signed [14:0]  pitch_cl;
    logic signed [19:0]  yaw_new;

    cep_pkg::t_cordic_req cq;
    cep_pkg::t_cordic_rsp cr;

    cep_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    cep_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cq),
        .o_rsp   (cr)
    );

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_load = (r_state == S_FIN) && (!r_m_valid || i_m_tready);

    // component k of the signed movement direction
    always_comb begin
        vec_c = 17'sd0;
        case (r_dir)
            cep_pkg::DIR_FWD, cep_pkg::DIR_BACK: begin
                case (r_k)
                    2'd0:    vec_c = 17'(r_fx);
                    2'd1:    vec_c = 17'(r_fy);
                    default: vec_c = 17'(r_fz);
                endcase
            end
            cep_pkg::DIR_LEFT, cep_pkg::DIR_RIGHT: begin
                case (r_k)
                    2'd0:    vec_c = 17'(r_rx);
                    2'd1:    vec_c = 17'sd0;
                    default: vec_c = 17'(r_rz);
                endcase
            end
            cep_pkg::DIR_UP, cep_pkg::DIR_DOWN: begin
                vec_c = (r_k == 2'd1) ? 17'(cep_pkg::VEC_ONE) : 17'sd0;
            end
            default: vec_c = 17'sd0;
        endcase
        if (r_dir == cep_pkg::DIR_BACK || r_dir == cep_pkg::DIR_LEFT ||
            r_dir == cep_pkg::DIR_DOWN) begin
            vec_c = -vec_c;
        end
    end

    // multiplier operands per step
    always_comb begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
        case (r_state)
            S_M_SPD: begin
                mul_a = $signed({17'd0, r_speed});
                mul_b = $signed({17'd0, r_time});
            end
            S_M_MUL: begin
                mul_a = $signed({1'b0, r_spd});
                mul_b = 33'(vec_c);
            end
            S_R_DY: begin
                mul_a = 33'(r_yd);
                mul_b = $signed({17'd0, r_sens});
            end
            S_R_DP: begin
                mul_a = 33'(r_pd);
                mul_b = $signed({17'd0, r_sens});
            end
            S_R_MUL: begin
                case (r_k)
                    2'd0:    begin mul_a = 33'(r_cy); mul_b = 33'(r_cp); end
                    2'd1:    begin mul_a = 33'(r_sy); mul_b = 33'(r_cp); end
                    2'd2:    begin mul_a = 33'(r_cy); mul_b = 33'(r_sp); end
                    default: begin mul_a = 33'(r_sy); mul_b = 33'(r_sp); end
                endcase
            end
            default: begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    assign rnd_p   = cep_pkg::rnd_shift(prod, 13);
    assign rnd_m   = cep_pkg::rnd_shift(prod, cep_pkg::MOVE_SHIFT);
    assign pos_sum = 34'(r_pos[r_k]) + rnd_m[33:0];
    assign pos_sat = (pos_sum > 34'sd2147483647)  ? 32'sh7FFF_FFFF :
                     (pos_sum < -34'sd2147483648) ? 32'sh8000_0000 : pos_sum[31:0];

    assign pitch_sum = 20'(r_pitch) + rnd_p[19:0];
    assign pitch_cl  = (pitch_sum > cep_pkg::PITCH_LIMIT)  ? 15'(cep_pkg::PITCH_LIMIT) :
                       (pitch_sum < -cep_pkg::PITCH_LIMIT) ? 15'(-cep_pkg::PITCH_LIMIT) :
                       pitch_sum[14:0];
    assign yaw_new   = r_acc - cep_pkg::YAW_HALF;

    always_comb begin
        cq.start = 1'b0;
        cq.angle = 16'sd0;
        if (r_state == S_R_WRP && r_acc >= 0 && r_acc < cep_pkg::YAW_TURN) begin
            cq.start = 1'b1;
            cq.angle = yaw_new[15:0];
        end else if (r_state == S_R_CY && cr.done) begin
            cq.start = 1'b1;
            cq.angle = 16'(r_pitch);
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_k     = 2'd0;
                    n_state = (i_s_tuser == cep_pkg::REQ_ROTATE) ? S_R_DY : S_M_SPD;
                end
            end
            S_M_SPD: n_state = S_M_LD;
            S_M_LD:  n_state = S_M_MUL;
            S_M_MUL: n_state = S_M_ACC;
            S_M_ACC: begin
                n_k     = r_k + 2'd1;
                n_state = (r_k == 2'd2) ? S_FIN : S_M_MUL;
            end
            S_R_DY:  n_state = S_R_DP;
            S_R_DP:  n_state = S_R_PCL;
            S_R_PCL: n_state = S_R_WRP;
            S_R_WRP: begin
                if (cq.start) begin
                    n_state = S_R_CY;
                end
            end
            S_R_CY: begin
                if (cr.done) begin
                    n_state = S_R_CP;
                end
            end
            S_R_CP: begin
                if (cr.done) begin
                    n_k     = 2'd0;
                    n_state = S_R_MUL;
                end
            end
            S_R_MUL: n_state = S_R_MST;
            S_R_MST: begin
                n_k     = r_k + 2'd1;
                n_state = (r_k == 2'd3) ? S_FIN : S_R_MUL;
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= 2'd0;
            r_m_valid <= 1'b0;
            r_speed   <= 16'd5248;
            r_sens    <= 16'd13107;
            r_pos[0]  <= 32'sd0;
            r_pos[1]  <= $signed(cep_pkg::POS_Y_RESET);
            r_pos[2]  <= 32'sd0;
            r_yaw     <= cep_pkg::YAW_RESET;
            r_pitch   <= 15'sd0;
            r_fx      <= 16'sd0;
            r_fy      <= 16'sd0;
            r_fz      <= -cep_pkg::VEC_ONE;
            r_rx      <= cep_pkg::VEC_ONE;
            r_rz      <= 16'sd0;
            r_ux      <= 16'sd0;
            r_uy      <= cep_pkg::VEC_ONE;
            r_uz      <= 16'sd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;

            if (i_psel && i_penable && i_pwrite) begin
                case (i_paddr[2])
                    cep_pkg::REG_MOVE_SPEED: r_speed <= i_pwdata[15:0];
                    cep_pkg::REG_LOOK_SENS:  r_sens  <= i_pwdata[15:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_M_ACC: r_pos[r_k] <= pos_sat;
                S_R_PCL: r_pitch <= pitch_cl;
                S_R_WRP: begin
                    if (cq.start) begin
                        r_yaw <= yaw_new[15:0];
                    end
                end
                S_R_CP: begin
                    if (cr.done) begin
                        r_fy <= cep_pkg::clamp_vec(cep_pkg::rnd_shift(64'(cr.sin_v), 16));
                        r_uy <= cep_pkg::clamp_vec(cep_pkg::rnd_shift(64'(cr.cos_v), 16));
                        r_rx <= cep_pkg::clamp_vec(-cep_pkg::rnd_shift(64'(r_sy), 16));
                        r_rz <= cep_pkg::clamp_vec(cep_pkg::rnd_shift(64'(r_cy), 16));
                    end
                end
                S_R_MST: begin
                    case (r_k)
                        2'd0:    r_fx <= cep_pkg::clamp_vec(cep_pkg::rnd_shift(prod, 46));
                        2'd1:    r_fz <= cep_pkg::clamp_vec(cep_pkg::rnd_shift(prod, 46));
                        2'd2:    r_ux <= cep_pkg::clamp_vec(-cep_pkg::rnd_shift(prod, 46));
                        default: r_uz <= cep_pkg::clamp_vec(-cep_pkg::rnd_shift(prod, 46));
                    endcase
                end
                default: ;
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_dir  <= i_s_tdata[2:0];
            r_time <= i_s_tdata[18:3];
            r_yd   <= $signed(i_s_tdata[34:19]);
            r_pd   <= $signed(i_s_tdata[50:35]);
        end
        if (r_state == S_M_LD) begin
            r_spd <= prod[31:0];
        end
        // yaw plus offset, then wrap one turn per cycle
        if (r_state == S_R_DP) begin
            r_acc <= 20'(r_yaw) + rnd_p[19:0] + cep_pkg::YAW_HALF;
        end else if (r_state == S_R_WRP) begin
            if (r_acc < 0) begin
                r_acc <= r_acc + cep_pkg::YAW_TURN;
            end else if (r_acc >= cep_pkg::YAW_TURN) begin
                r_acc <= r_acc - cep_pkg::YAW_TURN;
            end
        end
        if (r_state == S_R_CY && cr.done) begin
            r_cy <= cr.cos_v;
            r_sy <= cr.sin_v;
        end
        if (r_state == S_R_CP && cr.done) begin
            r_cp <= cr.cos_v;
            r_sp <= cr.sin_v;
        end
        if (out_load) begin
            r_m_data <= {1'b0, r_pitch, r_uz, r_uy, r_ux, r_rz, r_rx, r_fz, r_fy, r_fx,
                         r_pos[2], r_pos[1], r_pos[0]};
        end
    end

    always_comb begin
        case (i_paddr[2])
            cep_pkg::REG_MOVE_SPEED: o_prdata = {16'd0, r_speed};
            cep_pkg::REG_LOOK_SENS:  o_prdata = {16'd0, r_sens};
            default:                 o_prdata = 32'd0;
        endcase
    end

    assign o_pready   = 1'b1;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule
